### hw/rtl/channel_gamma_level_map_unit_assert.svh
// Assertion macros for the gamma level map block
`ifndef CHANNEL_GAMMA_LEVEL_MAP_UNIT_ASSERT_SVH
`define CHANNEL_GAMMA_LEVEL_MAP_UNIT_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define CGLM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cglm assertion failed");

// next-cycle implication, ignored while in reset
`define CGLM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cglm assertion failed");

`endif

### hw/rtl/cglm_pkg.sv
package cglm_pkg;

    // register indexes on the config port
    localparam logic [7:0] REG_THRESHOLD = 8'd0;
    localparam logic [7:0] REG_GAMMA     = 8'd1;
    localparam logic [7:0] REG_BLACK     = 8'd2;
    localparam logic [7:0] REG_WHITE     = 8'd3;

    localparam int LOG_FRAC = 20;
    localparam int EXP_STAGES = LOG_FRAC;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef logic [255:0][23:0] ntab_t;
    typedef logic [EXP_STAGES:0][29:0] ctab_t;

    // sideband carried through the exp2 chain
    typedef struct packed {
        logic       zero;
        logic [7:0] k;
    } exp_side_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
        logic [63:0] a;
        logic [63:0] r;
        logic [63:0] b;
        a = a_in;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (a >= r + b) begin
                a = a - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 of v (1..255), Q.20, truncated
    function automatic logic [23:0] log2_q20(input logic [7:0] v);
        logic [63:0] m;
        logic [23:0] res;
        int e;
        e = 0;
        for (int j = 1; j < 8; j++) begin
            if ((v >> j) != 8'd0) e = j;
        end
        m = 64'(v) << (30 - e);
        res = 24'(e) << LOG_FRAC;
        for (int i = 1; i <= LOG_FRAC; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                res = res | (24'd1 << (LOG_FRAC - i));
            end
        end
        return res;
    endfunction

    // log2(255) - log2(s) for every sample value
    function automatic ntab_t build_ntab();
        ntab_t t;
        t[0] = 24'd0;
        for (int s = 1; s < 256; s++) begin
            t[s] = log2_q20(8'd255) - log2_q20(8'(s));
        end
        return t;
    endfunction

    // c_i = 2^(-2^-i) in Q0.30
    function automatic ctab_t build_ctab();
        ctab_t t;
        logic [63:0] c;
        c = 64'h2000_0000;
        t[0] = 30'(c);
        for (int i = 1; i <= EXP_STAGES; i++) begin
            c = isqrt64(c << 30);
            t[i] = 30'(c);
        end
        return t;
    endfunction

    localparam ntab_t NTAB = build_ntab();
    localparam ctab_t CTAB = build_ctab();

endpackage

### hw/rtl/cglm_exp2.sv
// 2^-f pipeline: one conditional constant multiply per fraction bit
module cglm_exp2 (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [19:0]               in_f,
    input  cglm_pkg::exp_side_t       in_side,
    output logic                      out_valid,
    output logic [30:0]               out_y,
    output cglm_pkg::exp_side_t       out_side
);

    localparam int N = cglm_pkg::EXP_STAGES;

    logic                  v_reg    [1:N];
    logic [30:0]           y_reg    [1:N];
    logic [19:0]           f_reg    [1:N];
    cglm_pkg::exp_side_t   side_reg [1:N];

    for (genvar i = 1; i <= N; i++) begin : g_stg
        logic                v_prev;
        logic [30:0]         y_prev;
        logic [19:0]         f_prev;
        cglm_pkg::exp_side_t side_prev;
        logic [60:0]         prod;
        logic [30:0]         y_next;

        if (i == 1) begin : g_first
            assign v_prev    = in_valid;
            assign y_prev    = cglm_pkg::ONE_Q30;
            assign f_prev    = in_f;
            assign side_prev = in_side;
        end else begin : g_rest
            assign v_prev    = v_reg[i-1];
            assign y_prev    = y_reg[i-1];
            assign f_prev    = f_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        assign prod   = 61'(y_prev) * 61'(cglm_pkg::CTAB[i]);
        assign y_next = f_prev[N-i] ? 31'(prod >> 30) : y_prev;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                y_reg[i]    <= y_next;
                f_reg[i]    <= f_prev;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_y     = y_reg[N];
    assign out_side  = side_reg[N];

endmodule

### hw/rtl/channel_gamma_level_map_unit.sv
// Gamma / black-white level map for one 8-bit color channel.
// Input channel s_valid/s_ready/s_sample, result channel
// m_valid/m_ready/m_mapped_sample; both transactions complete when valid and
// ready are high at a rising aclk edge. Config writes use cfg_valid/cfg_ready
// with cfg_index (0 threshold, 1 gamma, 2 black, 3 white, others ignored)
// and cfg_data; cfg_ready is always high. Write config only while idle.
// One sample per cycle while not stalled. 27 register stages: threshold, log
// lookup, gamma multiply, 20-stage exp2 multiply chain, shift, level
// multiply, add and scale.
// The whole pipeline advances together; when m_valid is high and m_ready low
// every stage holds and s_ready drops, so nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and loads the
// register defaults: threshold 0, gamma 1.0, black 0, white 1.0.
module channel_gamma_level_map_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_mapped_sample,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [16:0]        thr_reg;
    logic [15:0]        gam_reg;
    logic signed [15:0] blk_reg;
    logic signed [15:0] wht_reg;

    logic en;

    // config registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= 17'd0;
            gam_reg <= 16'd4096;
            blk_reg <= 16'sd0;
            wht_reg <= 16'sd16384;
        end else if (cfg_valid) begin
            case (cfg_index)
                cglm_pkg::REG_THRESHOLD: thr_reg <= cfg_data[16:0];
                cglm_pkg::REG_GAMMA:     gam_reg <= cfg_data[15:0];
                cglm_pkg::REG_BLACK:     blk_reg <= signed'(cfg_data[15:0]);
                cglm_pkg::REG_WHITE:     wht_reg <= signed'(cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    // global advance
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage 1: threshold
    logic       v1_reg, zero1_reg;
    logic [7:0] smp1_reg;
    logic       zero1_next;
    assign zero1_next = (s_sample == 8'd0) ||
                        (25'({s_sample, 16'h0}) < (25'(thr_reg) * 25'd255));

    // stage 2: log lookup
    logic        v2_reg, zero2_reg;
    logic [23:0] n2_reg;

    // stage 3: gamma multiply
    logic        v3_reg, zero3_reg;
    logic [39:0] p3_next;
    logic [7:0]  k3_reg;
    logic [19:0] f3_reg;
    assign p3_next = 40'(gam_reg) * 40'(n2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero1_reg <= zero1_next;
            smp1_reg  <= s_sample;
            zero2_reg <= zero1_reg;
            n2_reg    <= cglm_pkg::NTAB[smp1_reg];
            zero3_reg <= zero2_reg;
            k3_reg    <= p3_next[39:32];
            f3_reg    <= p3_next[31:12];
        end
    end

    // exp2 chain
    logic                e_valid;
    logic [30:0]         e_y;
    cglm_pkg::exp_side_t e_side, e_in_side;
    assign e_in_side.zero = zero3_reg;
    assign e_in_side.k    = k3_reg;

    cglm_exp2 u_exp2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_f      (f3_reg),
        .in_side   (e_in_side),
        .out_valid (e_valid),
        .out_y     (e_y),
        .out_side  (e_side)
    );

    // integer shift and zero-sample case
    logic        vk_reg;
    logic [30:0] yk_reg, yk_next;
    always_comb begin
        if (e_side.zero) begin
            yk_next = (gam_reg == 16'd0) ? cglm_pkg::ONE_Q30 : 31'd0;
        end else if (e_side.k >= 8'd31) begin
            yk_next = 31'd0;
        end else begin
            yk_next = e_y >> e_side.k[4:0];
        end
    end

    // level multiply
    logic               vm_reg;
    logic signed [16:0] diff;
    logic signed [48:0] prod_reg, prod_next;
    assign diff      = 17'(wht_reg) - 17'(blk_reg);
    assign prod_next = 49'(diff) * signed'({18'd0, yk_reg});

    // black offset
    logic               va_reg;
    logic signed [48:0] acc_reg, acc_next;
    assign acc_next = prod_reg + (49'(blk_reg) <<< 30);

    // scale by 255, truncate, saturate
    logic               out_v_reg;
    logic [7:0]         out_reg, out_next;
    logic signed [57:0] scl;
    assign scl = (58'(acc_reg) <<< 8) - 58'(acc_reg);
    always_comb begin
        if (scl <= 58'sd0) begin
            out_next = 8'd0;
        end else if (scl[57:44] > 14'd255) begin
            out_next = 8'd255;
        end else begin
            out_next = scl[51:44];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vk_reg    <= 1'b0;
            vm_reg    <= 1'b0;
            va_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            vk_reg    <= e_valid;
            vm_reg    <= vk_reg;
            va_reg    <= vm_reg;
            out_v_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            yk_reg   <= yk_next;
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
            out_reg  <= out_next;
        end
    end

    assign m_valid         = out_v_reg;
    assign m_mapped_sample = out_reg;

    // checks
`include "channel_gamma_level_map_unit_assert.svh"
    `CGLM_ASSERT_NOW(a_ready_follows_out, 1'b1, s_ready == (!m_valid || m_ready))
    `CGLM_ASSERT_NEXT(a_stall_holds_out, m_valid && !m_ready, m_valid && $stable(m_mapped_sample))
    `CGLM_ASSERT_NEXT(a_stall_holds_pipe, !en, $stable(va_reg) && $stable(vm_reg))

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // index the block does not decode, must be ignored
    localparam logic [7:0] REG_UNUSED = 8'd9;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD = 300;

    typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_SAMPLE_CHK} row_kind_t;
    typedef struct {
        row_kind_t   kind;
        logic [7:0]  idx;
        logic [31:0] val;
        logic [7:0]  sample;
        logic [7:0]  known;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_sample;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_mapped_sample;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;

    // shadow of the level map registers
    logic [16:0]        thr_lvl;
    logic [15:0]        gam_exp;
    logic signed [15:0] blk_lvl;
    logic signed [15:0] wht_lvl;

    logic [23:0] log_full;
    logic [29:0] root_tab [0:20];
    logic [7:0]  mapped_q [$];
    logic        pin_en;
    logic [7:0]  pin_val;
    logic        no_idle;
    logic        hold_req;
    int          err_cnt;

    channel_gamma_level_map_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_mapped_sample(m_mapped_sample),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // integer square root, one result bit per step from the top
    function automatic logic [63:0] int_root(input logic [63:0] a);
        logic [63:0] r;
        logic [63:0] t;
        r = 64'd0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= a) r = t;
        end
        return r;
    endfunction

    // log2 of 1..255 with 20 fraction bits by repeated squaring
    function automatic logic [23:0] log2_fix(input logic [7:0] v);
        logic [63:0] mant;
        logic [23:0] acc;
        int msb;
        msb = 0;
        for (int j = 0; j < 8; j++) if (v[j]) msb = j;
        mant = 64'(v) << (30 - msb);
        acc = 24'(msb) << 20;
        for (int i = 19; i >= 0; i--) begin
            mant = (mant * mant) >> 30;
            if (mant[31]) begin
                mant = mant >> 1;
                acc[i] = 1'b1;
            end
        end
        return acc;
    endfunction

    // expected output level for one sample under the current registers
    function automatic logic [7:0] map_level(input logic [7:0] smp);
        logic [7:0]  s;
        logic [63:0] y;
        logic [63:0] p;
        logic [63:0] k;
        logic [19:0] f;
        longint      acc;
        longint      v;
        longint      res;
        s = smp;
        if (64'(s) * 64'd65536 < 64'(thr_lvl) * 64'd255) s = 8'd0;
        if (s == 8'd0) begin
            y = (gam_exp == 16'd0) ? (64'd1 << 30) : 64'd0;
        end else begin
            p = 64'(gam_exp) * 64'(log_full - log2_fix(s));
            k = p >> 32;
            f = p[31:12];
            y = 64'd1 << 30;
            for (int i = 1; i <= 20; i++) begin
                if (f[20 - i]) y = (y * 64'(root_tab[i])) >> 30;
            end
            y = (k >= 64'd31) ? 64'd0 : (y >> k);
        end
        acc = longint'(blk_lvl) * (longint'(1) <<< 30)
            + (longint'(wht_lvl) - longint'(blk_lvl)) * longint'(y);
        v = acc * 255;
        if (v <= 0) begin
            res = 0;
        end else begin
            res = v >>> 44;
            if (res > 255) res = 255;
        end
        return res[7:0];
    endfunction

    // transaction monitor: predict on accepted samples, check results
    always @(posedge aclk) begin
        logic [7:0] want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                mapped_q.push_back(pin_en ? pin_val : map_level(s_sample));
            end
            if (m_valid && m_ready) begin
                if (mapped_q.size() == 0) begin
                    $error("mapped_sample: unexpected result %0d", m_mapped_sample);
                    err_cnt++;
                end else begin
                    want = mapped_q.pop_front();
                    if (m_mapped_sample !== want) begin
                        $error("mapped_sample: expected %0d actual %0d",
                               want, m_mapped_sample);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(negedge aclk);
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (hold_req) stall = LONG_HOLD;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic cfg_write(input logic [7:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            cglm_pkg::REG_THRESHOLD: thr_lvl = val[16:0];
            cglm_pkg::REG_GAMMA:     gam_exp = val[15:0];
            cglm_pkg::REG_BLACK:     blk_lvl = val[15:0];
            cglm_pkg::REG_WHITE:     wht_lvl = val[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [7:0] smp, input logic pin,
                               input logic [7:0] pval);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        pin_en   <= pin;
        pin_val  <= pval;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // called at a falling edge right after the last accepted sample
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (mapped_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] rand_level();
        logic [15:0] lv;
        case ($urandom_range(0, 5))
            0: lv = 16'h7FFF;
            1: lv = 16'h8000;
            2: lv = 16'($urandom_range(0, 65535));
            default: lv = 16'($urandom_range(0, 20000)) - 16'd2000;
        endcase
        return {16'($urandom()), lv};
    endfunction

    row_t dir_rows [] = '{
        '{ROW_SAMPLE_CHK, 0, 0, 8'd0, 8'd0},
        '{ROW_SAMPLE_CHK, 0, 0, 8'd255, 8'd255},
        '{ROW_SAMPLE, 0, 0, 8'd128, 0},
        '{ROW_SAMPLE, 0, 0, 8'd1, 0},
        '{ROW_CFG, cglm_pkg::REG_GAMMA, 32'd0, 0, 0},
        '{ROW_SAMPLE_CHK, 0, 0, 8'd0, 8'd255},
        '{ROW_SAMPLE_CHK, 0, 0, 8'd7, 8'd255},
        '{ROW_CFG, cglm_pkg::REG_THRESHOLD, 32'd131071, 0, 0},
        '{ROW_SAMPLE_CHK, 0, 0, 8'd255, 8'd255},
        '{ROW_CFG, cglm_pkg::REG_GAMMA, 32'd4096, 0, 0},
        '{ROW_SAMPLE_CHK, 0, 0, 8'd255, 8'd0},
        '{ROW_CFG, cglm_pkg::REG_THRESHOLD, 32'hFFFE_0000, 0, 0},
        '{ROW_CFG, cglm_pkg::REG_BLACK, 32'd32767, 0, 0},
        '{ROW_CFG, cglm_pkg::REG_WHITE, 32'd32767, 0, 0},
        '{ROW_SAMPLE_CHK, 0, 0, 8'd100, 8'd255},
        '{ROW_CFG, cglm_pkg::REG_BLACK, 32'h0000_8000, 0, 0},
        '{ROW_CFG, cglm_pkg::REG_WHITE, 32'hFFFF_8000, 0, 0},
        '{ROW_SAMPLE_CHK, 0, 0, 8'd200, 8'd0},
        '{ROW_CFG, cglm_pkg::REG_BLACK, 32'd0, 0, 0},
        '{ROW_CFG, cglm_pkg::REG_WHITE, 32'd16384, 0, 0},
        '{ROW_CFG, cglm_pkg::REG_GAMMA, 32'd65535, 0, 0},
        '{ROW_SAMPLE, 0, 0, 8'd254, 0},
        '{ROW_SAMPLE_CHK, 0, 0, 8'd255, 8'd255},
        '{ROW_CFG, REG_UNUSED, 32'd0, 0, 0},
        '{ROW_SAMPLE_CHK, 0, 0, 8'd255, 8'd255},
        '{ROW_CFG, cglm_pkg::REG_GAMMA, 32'd2048, 0, 0},
        '{ROW_SAMPLE, 0, 0, 8'd64, 0}
    };

    // stimulus
    initial begin
        int n_items;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_sample  = 8'd0;
        cfg_valid = 1'b0;
        cfg_index = 8'd0;
        cfg_data  = 32'd0;
        pin_en    = 1'b0;
        pin_val   = 8'd0;
        no_idle   = 1'b0;
        hold_req  = 1'b0;
        err_cnt   = 0;
        thr_lvl   = 17'd0;
        gam_exp   = 16'd4096;
        blk_lvl   = 16'sd0;
        wht_lvl   = 16'sd16384;
        log_full  = log2_fix(8'd255);
        root_tab[0] = 30'h2000_0000;
        for (int i = 1; i <= 20; i++) begin
            root_tab[i] = 30'(int_root(64'(root_tab[i - 1]) << 30));
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(dir_rows[r].idx, dir_rows[r].val);
            end else begin
                send_sample(dir_rows[r].sample, dir_rows[r].kind == ROW_SAMPLE_CHK,
                            dir_rows[r].known);
            end
        end

        // random phases, each under its own register setting
        n_items = 0;
        for (int ph = 0; n_items < 1950; ph++) begin
            wait_idle();
            no_idle = (ph % 4 == 2);
            if (ph == 0) cfg_write(cglm_pkg::REG_THRESHOLD, 32'd0);
            else if (ph == 1) cfg_write(cglm_pkg::REG_THRESHOLD, 32'd131071);
            else if ($urandom_range(0, 2) == 0) cfg_write(cglm_pkg::REG_THRESHOLD, $urandom());
            else cfg_write(cglm_pkg::REG_THRESHOLD,
                           {15'($urandom()), 17'($urandom_range(0, 40000))});
            if (ph == 3) cfg_write(cglm_pkg::REG_GAMMA, 32'hFFFF);
            else if (ph == 4) cfg_write(cglm_pkg::REG_GAMMA, 32'd0);
            else if ($urandom_range(0, 3) == 0) cfg_write(cglm_pkg::REG_GAMMA, $urandom());
            else cfg_write(cglm_pkg::REG_GAMMA,
                           {16'($urandom()), 16'($urandom_range(0, 16384))});
            cfg_write(cglm_pkg::REG_BLACK, rand_level());
            cfg_write(cglm_pkg::REG_WHITE, rand_level());
            if ($urandom_range(0, 3) == 0) cfg_write(8'($urandom_range(4, 255)), $urandom());
            if (ph == 2) hold_req = 1'b1;
            for (int i = 0; i < 150; i++) begin
                send_sample(rand_sample(), 1'b0, 8'd0);
                n_items++;
                // occasional mid-phase pause until the pipeline has drained
                if (i == 75 && ph % 3 == 0) wait_idle();
            end
        end

        wait_idle();
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
